// ===== rtl/byte_stream_reassembler_unit_macros.svh =====
// ----------------------------------------------------------------------------
// byte stream reassembler assertion macros
// checks are compiled out when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_REASSEMBLER_UNIT_MACROS_SVH
`define BYTE_STREAM_REASSEMBLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reassembler check failed");
`define BSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reassembler check failed");
`else
`define BSR_ASSERT_IMP(lbl, ante, cons)
`define BSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg
// shared constants and types of the byte stream reassembler
// ----------------------------------------------------------------------------
package bsr_pkg;
  localparam int CAPACITY = 64;
  localparam int CAP_W    = $clog2(CAPACITY);
  localparam int CNT_W    = CAP_W + 1;

  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_SEG   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] stream_index;
    logic [7:0]  data_byte;
    logic [15:0] seg_length;
    logic        eof;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;
endpackage

// ===== rtl/bsr_front.sv =====
// ----------------------------------------------------------------------------
// bsr_front
// takes items from the command port and queues them for the back end
// ----------------------------------------------------------------------------
module bsr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bsr_pkg::item_t in_item,
  output bsr_pkg::q_head_t head,
  input  logic           pop
);
  import bsr_pkg::*;

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       do_pop;

  assign busy   = (count == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end
endmodule

// ===== rtl/bsr_back.sv =====
// ----------------------------------------------------------------------------
// bsr_back
// hold store, output fifo and the assembly sequencer
// ----------------------------------------------------------------------------
module bsr_back (
  input  logic             clk,
  input  logic             rst,
  input  bsr_pkg::q_head_t head,
  output logic             pop,
  output logic             done,
  output logic             read_valid,
  output logic [7:0]       read_byte,
  output logic             stream_ended,
  output logic [bsr_pkg::CNT_W-1:0] unassembled_count,
  output logic [bsr_pkg::CNT_W-1:0] output_count
);
  import bsr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ASM_RD = 2'd1;
  localparam logic [1:0] ST_ASM_WR = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  logic [1:0]       state;
  logic [7:0]       hold_store [CAPACITY];
  logic [7:0]       out_fifo   [CAPACITY];
  logic [CAPACITY-1:0] hold_valid;
  logic [CAP_W-1:0] hold_base;
  logic [CAP_W-1:0] out_head;
  logic [CNT_W-1:0] out_level;
  logic [CNT_W-1:0] held_count;
  logic [31:0]      assembled_count;
  logic [32:0]      end_index;
  logic             ended;
  logic             rd_valid;
  logic [7:0]       fifo_q;
  logic [7:0]       hold_q;

  logic [31:0]      offset;
  logic             in_window;
  logic             beyond;
  logic [CAP_W-1:0] slot;
  logic [CAP_W-1:0] tail;
  logic             fifo_room;
  logic             store_new;

  assign offset    = head.item.stream_index - assembled_count;
  assign in_window = (offset[31:CAP_W] == '0);
  assign beyond    = !in_window && !offset[31];
  assign slot      = hold_base + offset[CAP_W-1:0];
  assign tail      = out_head + out_level[CAP_W-1:0];
  assign fifo_room = (out_level < CNT_W'(CAPACITY));
  assign store_new = in_window && !hold_valid[slot];
  assign pop       = (state == ST_IDLE) && head.valid;

  assign done              = (state == ST_REPORT);
  assign read_valid        = rd_valid;
  assign read_byte         = rd_valid ? fifo_q : 8'd0;
  assign stream_ended      = ended;
  assign unassembled_count = held_count;
  assign output_count      = out_level;

  // memories
  always_ff @(posedge clk) begin
    if (pop && head.item.cmd == CMD_STORE && store_new) begin
      hold_store[slot] <= head.item.data_byte;
    end
    if (state == ST_ASM_RD) begin
      hold_q <= hold_store[hold_base];
    end
    if (state == ST_ASM_WR) begin
      out_fifo[tail] <= hold_q;
    end
    if (pop) begin
      fifo_q <= out_fifo[out_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      hold_valid      <= '0;
      hold_base       <= '0;
      out_head        <= '0;
      out_level       <= '0;
      held_count      <= '0;
      assembled_count <= '0;
      end_index       <= '1;
      ended           <= 1'b0;
      rd_valid        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            rd_valid <= 1'b0;
            state    <= ST_REPORT;
            case (head.item.cmd)
              CMD_STORE: begin
                if (store_new) begin
                  hold_valid[slot] <= 1'b1;
                  held_count       <= held_count + CNT_W'(1);
                end
              end
              CMD_SEG: begin
                if (!beyond) begin
                  if (head.item.eof) begin
                    end_index <= {1'b0, head.item.stream_index
                                        + {16'd0, head.item.seg_length}};
                  end
                  state <= ST_ASM_RD;
                end
              end
              CMD_READ: begin
                if (out_level != '0) begin
                  rd_valid  <= 1'b1;
                  out_head  <= out_head + CAP_W'(1);
                  out_level <= out_level - CNT_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_ASM_RD: begin
          if (fifo_room && hold_valid[hold_base]) begin
            state <= ST_ASM_WR;
          end else begin
            if (end_index == {1'b0, assembled_count}) begin
              ended <= 1'b1;
            end
            state <= ST_REPORT;
          end
        end
        ST_ASM_WR: begin
          hold_valid[hold_base] <= 1'b0;
          hold_base       <= hold_base + CAP_W'(1);
          out_level       <= out_level + CNT_W'(1);
          held_count      <= held_count - CNT_W'(1);
          assembled_count <= assembled_count + 32'd1;
          state           <= ST_ASM_RD;
        end
        ST_REPORT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/byte_stream_reassembler_unit.sv =====
// ----------------------------------------------------------------------------
// byte_stream_reassembler_unit
// rebuilds an in-order byte stream from out-of-order bytes
//
// channel  direction  handshake          payload
// command  in         start / busy       cmd, stream_index, data_byte,
//                                        seg_length, eof
// result   out        done (one cycle)   read_valid, read_byte, stream_ended,
//                                        unassembled_count, output_count
//
// store, read and unused items go to the report state in the back end, a segment
// end in range first moves each byte by a hold store read then a fifo write
// a two-item queue lets the port take items while the back end works
// synchronous reset clears the hold valid bits and all counters at once
// the receiver cannot stall: each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
`include "byte_stream_reassembler_unit_macros.svh"
module byte_stream_reassembler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] stream_index,
  input  logic [7:0]  data_byte,
  input  logic [15:0] seg_length,
  input  logic        eof,
  output logic        done,
  output logic        read_valid,
  output logic [7:0]  read_byte,
  output logic        stream_ended,
  output logic [bsr_pkg::CNT_W-1:0] unassembled_count,
  output logic [bsr_pkg::CNT_W-1:0] output_count
);
  import bsr_pkg::*;

  item_t   in_item;
  q_head_t head;
  logic    pop;

  assign in_item.cmd          = cmd;
  assign in_item.stream_index = stream_index;
  assign in_item.data_byte    = data_byte;
  assign in_item.seg_length   = seg_length;
  assign in_item.eof          = eof;

  bsr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .head    (head),
    .pop     (pop)
  );

  bsr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .pop               (pop),
    .done              (done),
    .read_valid        (read_valid),
    .read_byte         (read_byte),
    .stream_ended      (stream_ended),
    .unassembled_count (unassembled_count),
    .output_count      (output_count)
  );

  `BSR_ASSERT_IMP(a_counts_bounded, done, (unassembled_count <= CNT_W'(CAPACITY)) && (output_count <= CNT_W'(CAPACITY)))
  `BSR_ASSERT_IMP(a_empty_read_zero, done && !read_valid, read_byte == 8'd0)
  `BSR_ASSERT_NEXT(a_single_strobe, done, !done)
  `BSR_ASSERT_NEXT(a_ended_sticky, stream_ended, stream_ended)
endmodule

// ===== dv/tb_byte_stream_reassembler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_byte_stream_reassembler_unit
// drives store, segment-end and read items into the reassembler, predicts
// every result with a behavioural copy of the window, hold store and output
// fifo, and compares each strobed result field by field
// ----------------------------------------------------------------------------
module tb_byte_stream_reassembler_unit;
  import bsr_pkg::*;

  localparam logic [1:0]  CMD_NONE = 2'd3;
  localparam logic [32:0] NO_END   = 33'h1_FFFF_FFFF;

  typedef struct packed {
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       ended;
    logic [6:0] held;
    logic [6:0] level;
  } outcome_t;

  typedef struct {
    item_t    it;
    logic     known;
    outcome_t res;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [1:0]  cmd = '0;
  logic [31:0] stream_index = '0;
  logic [7:0]  data_byte = '0;
  logic [15:0] seg_length = '0;
  logic        eof = 0;
  logic        busy, done, read_valid, stream_ended;
  logic [7:0]  read_byte;
  logic [CNT_W-1:0] unassembled_count, output_count;

  byte_stream_reassembler_unit uut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [7:0]  held_bytes [CAPACITY];
  logic        held_mark  [CAPACITY];
  logic [7:0]  fifo_bytes [CAPACITY];
  logic [5:0]  fifo_head, base_slot;
  int unsigned fifo_level, held_total;
  logic [31:0] asm_pos;
  logic [32:0] end_pos;
  logic        ended_mark;

  outcome_t expected_q [$];
  int       errors = 0;
  row_t     rows [$];

  function automatic outcome_t predict_item(item_t it);
    outcome_t r;
    logic [31:0] off;
    logic [5:0] s, tail;
    r = '0;
    off = it.stream_index - asm_pos;
    case (it.cmd)
      CMD_STORE: begin
        if (off < CAPACITY) begin
          s = base_slot + off[5:0];
          if (!held_mark[s]) begin
            held_bytes[s] = it.data_byte;
            held_mark[s] = 1;
            held_total++;
          end
        end
      end
      CMD_SEG: begin
        if (!(off >= CAPACITY && off < 32'h8000_0000)) begin
          if (it.eof) end_pos = {1'b0, it.stream_index + {16'd0, it.seg_length}};
          while (fifo_level < CAPACITY && held_mark[base_slot]) begin
            tail = fifo_head + fifo_level[5:0];
            fifo_bytes[tail] = held_bytes[base_slot];
            fifo_level++;
            held_mark[base_slot] = 0;
            held_total--;
            asm_pos++;
            base_slot++;
          end
          if (end_pos == {1'b0, asm_pos}) ended_mark = 1;
        end
      end
      CMD_READ: begin
        if (fifo_level > 0) begin
          r.rd_valid = 1;
          r.rd_byte = fifo_bytes[fifo_head];
          fifo_head++;
          fifo_level--;
        end
      end
      default: ;
    endcase
    r.ended = ended_mark;
    r.held  = held_total[6:0];
    r.level = fifo_level[6:0];
    return r;
  endfunction

  // start stays high between back-to-back items; it drops only for a gap
  task automatic send_item(item_t it, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    while (busy) @(negedge clk);
    start <= 1;
    cmd <= it.cmd;
    stream_index <= it.stream_index;
    data_byte <= it.data_byte;
    seg_length <= it.seg_length;
    eof <= it.eof;
    @(posedge clk);
    expected_q.push_back(predict_item(it));
  endtask

  function automatic item_t mk(logic [1:0] c, logic [31:0] p, logic [7:0] d,
                               logic [15:0] l, logic e);
    item_t it;
    it.cmd = c; it.stream_index = p; it.data_byte = d; it.seg_length = l; it.eof = e;
    return it;
  endfunction

  function automatic void add_row(item_t it, logic known, outcome_t res);
    row_t r;
    r.it = it; r.known = known; r.res = res;
    rows.push_back(r);
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (read_valid !== e.rd_valid) begin
          $error("read_valid exp %0h got %0h", e.rd_valid, read_valid); errors++;
        end
        if (read_byte !== e.rd_byte) begin
          $error("read_byte exp %0h got %0h", e.rd_byte, read_byte); errors++;
        end
        if (stream_ended !== e.ended) begin
          $error("stream_ended exp %0h got %0h", e.ended, stream_ended); errors++;
        end
        if (unassembled_count !== e.held) begin
          $error("unassembled_count exp %0d got %0d", e.held, unassembled_count); errors++;
        end
        if (output_count !== e.level) begin
          $error("output_count exp %0d got %0d", e.level, output_count); errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    outcome_t z, p;
    outcome_t got;
    logic [31:0] seg_base, r32;
    int n, k, sent, perm [$];
    logic fill_mode;

    for (int i = 0; i < CAPACITY; i++) held_mark[i] = 0;
    fifo_head = 0; base_slot = 0; fifo_level = 0; held_total = 0;
    asm_pos = 0; end_pos = NO_END; ended_mark = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed table; known results only where obvious
    z = '0;
    add_row(mk(CMD_READ, 32'd0, 8'd0, 16'd0, 1'b0), 1'b1, z);           // read when empty
    add_row(mk(CMD_NONE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1), 1'b1, z); // unused command
    add_row(mk(CMD_STORE, 32'd64, 8'hAA, 16'd0, 1'b0), 1'b1, z);        // just outside window
    add_row(mk(CMD_STORE, 32'hFFFF_FFFF, 8'hAA, 16'd0, 1'b0), 1'b1, z); // already assembled side
    p = z; p.held = 1;
    add_row(mk(CMD_STORE, 32'd63, 8'hFF, 16'd0, 1'b0), 1'b1, p);        // top of window
    p.held = 2;
    add_row(mk(CMD_STORE, 32'd0, 8'h00, 16'hFFFF, 1'b1), 1'b1, p);
    add_row(mk(CMD_STORE, 32'd0, 8'h55, 16'd0, 1'b0), 1'b1, p);         // already held, kept
    add_row(mk(CMD_SEG, 32'd64, 8'd0, 16'd1, 1'b1), 1'b1, p);           // segment beyond window
    add_row(mk(CMD_SEG, 32'd0, 8'd0, 16'd0, 1'b0), 1'b0, z);
    add_row(mk(CMD_READ, 32'd0, 8'd0, 16'd0, 1'b0), 1'b0, z);
    for (int i = 1; i < 63; i++)
      add_row(mk(CMD_STORE, 32'(i), 8'(i * 37), 16'd0, 1'b0), 1'b0, z);
    add_row(mk(CMD_SEG, 32'hF000_0000, 8'd0, 16'hFFFF, 1'b0), 1'b0, z); // behind point
    add_row(mk(CMD_STORE, 32'd64, 8'h11, 16'd0, 1'b0), 1'b0, z);
    add_row(mk(CMD_STORE, 32'd65, 8'h12, 16'd0, 1'b0), 1'b0, z);
    add_row(mk(CMD_SEG, 32'd1, 8'd0, 16'd0, 1'b0), 1'b0, z);             // fifo fills up
    add_row(mk(CMD_READ, 32'd0, 8'd0, 16'd0, 1'b0), 1'b0, z);
    add_row(mk(CMD_SEG, 32'd60, 8'd0, 16'd6, 1'b1), 1'b0, z);            // eof, end at 66
    for (int i = 0; i < 4; i++)
      add_row(mk(CMD_READ, 32'd0, 8'd0, 16'd0, 1'b0), 1'b0, z);
    add_row(mk(CMD_SEG, 32'd66, 8'd0, 16'd0, 1'b0), 1'b0, z);

    foreach (rows[i]) begin
      send_item(rows[i].it, $urandom_range(0, 6));
      if (rows[i].known) begin
        got = expected_q[$];
        if (got !== rows[i].res) begin
          $error("directed row %0d exp %h predicted %h", i, rows[i].res, got);
          errors++;
        end
      end
    end

    // random part: mostly segments near the assembly point, shuffled or in order
    sent = 0;
    while (sent < 1150) begin
      if ($urandom_range(0, 15) == 0) begin
        // hold off until every expected result is in
        @(negedge clk);
        start <= 0;
        while (expected_q.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(1, 12);
        r32 = $urandom;
        seg_base = asm_pos + $urandom_range(0, 20);
        if ($urandom_range(0, 7) == 0) seg_base = r32;
        fill_mode = $urandom_range(0, 1);
        perm.delete();
        for (int i = 0; i < n; i++) perm.push_back(i);
        if (fill_mode) perm.shuffle();
        foreach (perm[i]) begin
          send_item(mk(CMD_STORE, seg_base + 32'(perm[i]), 8'($urandom), 16'($urandom),
                       1'($urandom)),
                    $urandom_range(0, 6) * $urandom_range(0, 1));
          sent++;
        end
        k = $urandom_range(0, 20);
        send_item(mk(CMD_SEG, (k == 0) ? asm_pos + 32'h8000_0000 : seg_base,
                     8'($urandom), (k < 3) ? 16'($urandom) : 16'(n), k < 2),
                  $urandom_range(0, 6));
        sent++;
        k = $urandom_range(0, n + 4);
        for (int i = 0; i < k; i++) begin
          send_item(mk(CMD_READ, $urandom, 8'($urandom), 16'($urandom), 1'($urandom)),
                    $urandom_range(0, 6));
          sent++;
        end
      end else begin
        send_item(mk(2'($urandom), $urandom, 8'($urandom), 16'($urandom), 1'($urandom)),
                  $urandom_range(0, 6));
        sent++;
      end
    end

    @(negedge clk);
    start <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
